// File: src/mfdp_pkg.sv
// ----------------------------------------------------------------------------
// mfdp_pkg
// Shared types and constants for the marker-framed decimal field parser.
// ----------------------------------------------------------------------------
package mfdp_pkg;

    localparam logic [7:0] CHAR_E     = 8'h65;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] CHAR_D     = 8'h64;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    localparam int MANT_W = 33;
    localparam int MAG_W  = 50;
    localparam int POW_W  = 17;
    localparam logic [MANT_W-1:0] MANT_CAP = 33'h1_0000_0000;
    localparam logic [2:0] FRAC_MAX = 3'd5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_PARSE  = 3'b010,
        PH_DONE   = 3'b100
    } parse_phase_t;

    typedef enum logic [6:0] {
        FP_BETWEEN = 7'b000_0001,
        FP_BLANK   = 7'b000_0010,
        FP_SIGN    = 7'b000_0100,
        FP_INT     = 7'b000_1000,
        FP_DOT     = 7'b001_0000,
        FP_FRAC    = 7'b010_0000,
        FP_STOP    = 7'b100_0000
    } field_phase_t;

    typedef struct packed {
        logic [3:0]        index;
        logic [MANT_W-1:0] mantissa;
        logic [2:0]        frac_digits;
        logic              negative;
        logic              final_cell;
    } cell_req_t;

    function automatic logic [POW_W-1:0] scale_pow10(input logic [2:0] frac_digits);
        logic [POW_W-1:0] p;
        begin
            case (frac_digits)
                3'd0:    p = 17'd100000;
                3'd1:    p = 17'd10000;
                3'd2:    p = 17'd1000;
                3'd3:    p = 17'd100;
                3'd4:    p = 17'd10;
                default: p = 17'd1;
            endcase
            return p;
        end
    endfunction

endpackage

// File: src/mfdp_front.sv
// ----------------------------------------------------------------------------
// mfdp_front
// Marker hunt, field split and per-byte decimal accumulation. Issues one
// scale request per closed non-empty field.
// ----------------------------------------------------------------------------
module mfdp_front #(
    parameter int CELL_COUNT = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_valid,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_end,
    output logic                 req_valid,
    output mfdp_pkg::cell_req_t  req
);
    import mfdp_pkg::*;

    localparam logic [5:0] CELL_LIMIT = 6'(CELL_COUNT);

    parse_phase_t       phase_reg, phase_next;
    logic [1:0]         marker_reg, marker_next;
    logic [4:0]         cells_reg, cells_next;
    field_phase_t       fphase_reg, fphase_next;
    logic [MANT_W-1:0]  mant_reg, mant_next;
    logic [2:0]         frac_reg, frac_next;
    logic               neg_reg, neg_next;

    field_phase_t       fb_phase;
    logic [MANT_W-1:0]  fb_mant;
    logic [2:0]         fb_frac;
    logic               fb_neg;

    logic               is_digit;
    logic               is_blank;
    logic [3:0]         digit;
    logic [36:0]        mant_x10;
    logic [MANT_W-1:0]  mant_acc;
    logic               emit;
    logic               closing;
    logic [4:0]         cells_inc;
    logic               limit_hit;

    assign is_digit = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
    assign is_blank = (rx_byte == CHAR_SPACE) || ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
    assign digit    = 4'(rx_byte - CHAR_0);
    assign mant_x10 = (37'(mant_reg) << 3) + (37'(mant_reg) << 1) + 37'(digit);
    assign mant_acc = (mant_x10 > 37'(MANT_CAP)) ? MANT_CAP : mant_x10[MANT_W-1:0];

    always_comb begin
        fb_phase = fphase_reg;
        fb_mant  = mant_reg;
        fb_frac  = frac_reg;
        fb_neg   = neg_reg;
        if (is_digit) begin
            unique case (fphase_reg)
                FP_BETWEEN, FP_BLANK, FP_SIGN, FP_INT: begin
                    fb_phase = FP_INT;
                    fb_mant  = mant_acc;
                end
                FP_DOT, FP_FRAC: begin
                    fb_phase = FP_FRAC;
                    if (frac_reg < FRAC_MAX) begin
                        fb_mant = mant_acc;
                        fb_frac = frac_reg + 3'd1;
                    end
                end
                default: ;
            endcase
        end else if (rx_byte == CHAR_DOT) begin
            unique case (fphase_reg)
                FP_BETWEEN, FP_BLANK, FP_SIGN: fb_phase = FP_DOT;
                FP_INT:                        fb_phase = FP_FRAC;
                default:                       fb_phase = FP_STOP;
            endcase
        end else if ((rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS)) begin
            if ((fphase_reg == FP_BETWEEN) || (fphase_reg == FP_BLANK)) begin
                fb_phase = FP_SIGN;
                fb_neg   = (rx_byte == CHAR_MINUS);
            end else begin
                fb_phase = FP_STOP;
            end
        end else if (is_blank && ((fphase_reg == FP_BETWEEN) || (fphase_reg == FP_BLANK))) begin
            fb_phase = FP_BLANK;
        end else begin
            fb_phase = FP_STOP;
        end
    end

    assign cells_inc = cells_reg + 5'd1;
    assign limit_hit = (6'(cells_inc) >= CELL_LIMIT) || (cells_inc == 5'd0);

    always_comb begin
        phase_next  = phase_reg;
        marker_next = marker_reg;
        cells_next  = cells_reg;
        fphase_next = fphase_reg;
        mant_next   = mant_reg;
        frac_next   = frac_reg;
        neg_next    = neg_reg;
        emit        = 1'b0;
        closing     = 1'b0;

        unique case (phase_reg)
            PH_SEARCH: begin
                if ((marker_reg == 2'd2) && (rx_byte == CHAR_D)) begin
                    phase_next  = PH_PARSE;
                    marker_next = 2'd0;
                end else if ((marker_reg == 2'd1) && (rx_byte == CHAR_N)) begin
                    marker_next = 2'd2;
                end else begin
                    marker_next = (rx_byte == CHAR_E) ? 2'd1 : 2'd0;
                end
            end
            PH_PARSE: begin
                if (rx_byte == CHAR_NUL) begin
                    emit       = (fphase_reg != FP_BETWEEN);
                    closing    = 1'b1;
                    phase_next = PH_DONE;
                end else if (rx_byte == CHAR_SEMI) begin
                    emit    = (fphase_reg != FP_BETWEEN);
                    closing = frame_end;
                end else begin
                    fphase_next = fb_phase;
                    mant_next   = fb_mant;
                    frac_next   = fb_frac;
                    neg_next    = fb_neg;
                    emit        = frame_end;
                    closing     = 1'b1;
                end
            end
            default: ;
        endcase

        req.index       = cells_reg[3:0];
        req.mantissa    = mant_next;
        req.frac_digits = frac_next;
        req.negative    = neg_next;
        req.final_cell  = closing || limit_hit;

        if (emit) begin
            cells_next  = cells_inc;
            fphase_next = FP_BETWEEN;
            mant_next   = '0;
            frac_next   = '0;
            neg_next    = 1'b0;
            if (limit_hit) begin
                phase_next = PH_DONE;
            end
        end

        if (frame_end) begin
            phase_next  = PH_SEARCH;
            marker_next = 2'd0;
            cells_next  = '0;
            fphase_next = FP_BETWEEN;
            mant_next   = '0;
            frac_next   = '0;
            neg_next    = 1'b0;
        end
    end

    assign req_valid = byte_valid && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SEARCH;
            marker_reg <= 2'd0;
            cells_reg  <= '0;
            fphase_reg <= FP_BETWEEN;
            mant_reg   <= '0;
            frac_reg   <= '0;
            neg_reg    <= 1'b0;
        end else if (byte_valid) begin
            phase_reg  <= phase_next;
            marker_reg <= marker_next;
            cells_reg  <= cells_next;
            fphase_reg <= fphase_next;
            mant_reg   <= mant_next;
            frac_reg   <= frac_next;
            neg_reg    <= neg_next;
        end
    end

endmodule

// File: src/mfdp_queue.sv
// ----------------------------------------------------------------------------
// mfdp_queue
// Small FIFO of scale requests between the parser and the scaling pipeline.
// ----------------------------------------------------------------------------
module mfdp_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  mfdp_pkg::cell_req_t        push_data,
    input  logic                       pop,
    output logic                       head_valid,
    output mfdp_pkg::cell_req_t        head_data,
    output logic [mfdp_pkg::QCNT_W-1:0] count
);
    import mfdp_pkg::*;

    cell_req_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign do_pop      = pop && (count_reg != '0);
    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_comb begin
        count_next = count_reg;
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

// File: src/mfdp_back.sv
// ----------------------------------------------------------------------------
// mfdp_back
// Scaling pipeline: multiply by the power of ten, then saturate into the
// output register.
// ----------------------------------------------------------------------------
module mfdp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    input  mfdp_pkg::cell_req_t req,
    output logic                req_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          out_index,
    output logic [31:0]         out_value,
    output logic                out_final
);
    import mfdp_pkg::*;

    logic               s1_valid_reg;
    logic [MAG_W-1:0]   s1_mag_reg;
    logic               s1_neg_reg;
    logic [3:0]         s1_index_reg;
    logic               s1_final_reg;

    logic               out_valid_reg;
    logic [3:0]         out_index_reg;
    logic [31:0]        out_value_reg;
    logic               out_final_reg;

    logic               s2_ready;
    logic               s1_ready;
    logic [MAG_W-1:0]   mag;
    logic [31:0]        sat_value;

    assign s2_ready  = !out_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req_ready = s1_ready;
    assign mag       = MAG_W'(req.mantissa) * MAG_W'(scale_pow10(req.frac_digits));

    always_comb begin
        if (s1_neg_reg) begin
            if (s1_mag_reg >= MAG_W'(64'h8000_0000)) begin
                sat_value = 32'h8000_0000;
            end else begin
                sat_value = 32'd0 - s1_mag_reg[31:0];
            end
        end else begin
            if (s1_mag_reg > MAG_W'(64'h7FFF_FFFF)) begin
                sat_value = 32'h7FFF_FFFF;
            end else begin
                sat_value = s1_mag_reg[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_mag_reg   <= mag;
            s1_neg_reg   <= req.negative;
            s1_index_reg <= req.index;
            s1_final_reg <= req.final_cell;
        end
        if (s2_ready) begin
            out_index_reg <= s1_index_reg;
            out_value_reg <= sat_value;
            out_final_reg <= s1_final_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= req_valid;
            end
            if (s2_ready) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign out_final = out_final_reg;

endmodule

// File: src/marker_framed_decimal_field_parser.sv
// ----------------------------------------------------------------------------
// marker_framed_decimal_field_parser
// Hunts for "end" in a byte stream, splits the rest on ';' and emits each
// field as a fixed-point decimal (value * 100000) with its cell index.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : one frame character per transaction in s_tdata[7:0]; s_tlast marks
//         the last byte of the frame and clears all parser state after it.
//   m_* : one transaction per non-empty field; m_tdata holds the cell index and
//         the signed scaled value, m_tlast is set on the last cell of a frame.
//   Throughput: one byte per cycle while s_tready is high; per-byte work
//   is a single accumulate step of the parser front end.
//   Path: a cell closed by an accepted byte is written to a queue slot at
//   the edge that accepts that byte, then passes the multiply stage and
//   the saturate/output register before it appears on m_*.
//   Reset: aresetn low for one cycle empties the queue and pipeline and puts
//   the parser back in marker search.
//   Stall: while m_tready is low the pipeline holds and the two-entry queue
//   fills; s_tready drops only when the queue is full.
// ----------------------------------------------------------------------------
module marker_framed_decimal_field_parser #(
    parameter int CELL_COUNT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] cell_index, [35:4] cell_value, [39:36] zero
    output logic        m_tlast
);
    import mfdp_pkg::*;

    logic               byte_accept;
    logic               front_valid;
    cell_req_t          front_req;
    logic               q_valid;
    cell_req_t          q_head;
    logic [QCNT_W-1:0]  q_count;
    logic               back_ready;
    logic [3:0]         cell_index;
    logic [31:0]        cell_value;

    assign s_tready    = (q_count != QCNT_W'(QUEUE_DEPTH));
    assign byte_accept = s_tvalid && s_tready;

    mfdp_front #(
        .CELL_COUNT(CELL_COUNT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_accept),
        .rx_byte    (s_tdata),
        .frame_end  (s_tlast),
        .req_valid  (front_valid),
        .req        (front_req)
    );

    mfdp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_valid),
        .push_data  (front_req),
        .pop        (back_ready),
        .head_valid (q_valid),
        .head_data  (q_head),
        .count      (q_count)
    );

    mfdp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (q_valid),
        .req       (q_head),
        .req_ready (back_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (cell_index),
        .out_value (cell_value),
        .out_final (m_tlast)
    );

    assign m_tdata = {4'd0, cell_value, cell_index};

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready && !q_valid)
        else $error("pipeline not empty after reset");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_queue_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (q_count == $past(q_count)) ||
                           (q_count == $past(q_count) + 2'd1) ||
                           (q_count == $past(q_count) - 2'd1))
        else $error("queue count moved by more than one");

    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid == (q_count != '0))
        else $error("queue head valid disagrees with count");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for marker_framed_decimal_field_parser. Frames of text
// are streamed in one character per transaction. A behavioral parser inside
// the bench tracks the marker hunt, splitting on ';', the decimal field
// reader and the cell limit. It queues the cells that each accepted
// character should produce. Every output transaction is compared field by
// field against the oldest queued cell. Directed frames come first, then
// random frames under several idle patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfdp_pkg::*;

    localparam int CELLS        = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [3:0]  index;
        logic [31:0] value;
        logic        final_cell;
    } cell_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // behavioral parser state
    parse_phase_t ph;
    field_phase_t fph;
    logic [1:0]   mark_cnt;
    logic [4:0]   cells_out;
    logic [32:0]  mant;
    logic [2:0]   frac_cnt;
    logic         neg_sign;

    cell_t      pending_cells[$];
    logic [7:0] frame_buf[$];

    int send_idle_pct = 33;
    int recv_idle_pct = 47;
    int hold_len      = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int errors        = 0;
    int chars_sent    = 0;
    int frames_sent   = 0;
    int cells_checked = 0;
    int cycle_count   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    marker_framed_decimal_field_parser #(
        .CELL_COUNT(CELLS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    task automatic clear_number();
        fph      = FP_BETWEEN;
        mant     = '0;
        frac_cnt = '0;
        neg_sign = 1'b0;
    endtask

    task automatic reset_parser();
        ph        = PH_SEARCH;
        mark_cnt  = '0;
        cells_out = '0;
        clear_number();
    endtask

    task automatic shift_digit(input logic [3:0] d);
        logic [63:0] m;
        m = 64'(mant) * 64'd10 + 64'(d);
        mant = (m > 64'(MANT_CAP)) ? MANT_CAP : m[32:0];
    endtask

    task automatic close_cell(input logic closing);
        cell_t       c;
        logic [63:0] scale;
        logic [63:0] mag;
        logic        shut;
        shut = closing;
        case (frac_cnt)
            3'd0:    scale = 64'd100000;
            3'd1:    scale = 64'd10000;
            3'd2:    scale = 64'd1000;
            3'd3:    scale = 64'd100;
            3'd4:    scale = 64'd10;
            default: scale = 64'd1;
        endcase
        mag = 64'(mant) * scale;
        if (neg_sign) begin
            c.value = (mag >= 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
        end else begin
            c.value = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        c.index   = cells_out[3:0];
        cells_out = cells_out + 5'd1;
        clear_number();
        if (cells_out >= CELLS || cells_out == 5'd0) begin
            ph   = PH_DONE;
            shut = 1'b1;
        end
        c.final_cell = shut;
        pending_cells.push_back(c);
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last);
        logic pre_num;
        logic pre_dot;
        pre_num = (fph == FP_BETWEEN) || (fph == FP_BLANK);
        pre_dot = pre_num || (fph == FP_SIGN);
        case (ph)
            PH_SEARCH: begin
                if (mark_cnt == 2'd2 && c == CHAR_D) begin
                    ph       = PH_PARSE;
                    mark_cnt = 2'd0;
                end else if (mark_cnt == 2'd1 && c == CHAR_N) begin
                    mark_cnt = 2'd2;
                end else begin
                    mark_cnt = (c == CHAR_E) ? 2'd1 : 2'd0;
                end
            end
            PH_PARSE: begin
                if (c == CHAR_NUL) begin
                    if (fph != FP_BETWEEN) close_cell(1'b1);
                    ph = PH_DONE;
                end else if (c == CHAR_SEMI) begin
                    if (fph != FP_BETWEEN) close_cell(last);
                end else begin
                    if (c >= CHAR_0 && c <= CHAR_9) begin
                        if (pre_dot || fph == FP_INT) begin
                            fph = FP_INT;
                            shift_digit(4'(c - CHAR_0));
                        end else if (fph == FP_DOT || fph == FP_FRAC) begin
                            fph = FP_FRAC;
                            if (frac_cnt < FRAC_MAX) begin
                                shift_digit(4'(c - CHAR_0));
                                frac_cnt = frac_cnt + 3'd1;
                            end
                        end
                    end else if (c == CHAR_DOT) begin
                        if (pre_dot) fph = FP_DOT;
                        else if (fph == FP_INT) fph = FP_FRAC;
                        else fph = FP_STOP;
                    end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        if (pre_num) begin
                            fph      = FP_SIGN;
                            neg_sign = (c == CHAR_MINUS);
                        end else begin
                            fph = FP_STOP;
                        end
                    end else if ((c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
                                 && pre_num) begin
                        fph = FP_BLANK;
                    end else begin
                        fph = FP_STOP;
                    end
                    if (last) close_cell(1'b1);
                end
            end
            default: ;
        endcase
        if (last) reset_parser();
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        parse_char(c, last);
        chars_sent++;
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            send_char(frame_buf[i], i == frame_buf.size() - 1);
        end
        if (frame_buf.size() != 0) frames_sent++;
        frame_buf.delete();
    endtask

    // sender pauses until the output side has caught up
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_no_marker();
        add_str("en");
        frame_buf.push_back(CHAR_NUL);
        add_str("d;7");
        send_frame();
    endtask

    task automatic test_number_forms();
        add_str("eend");
        frame_buf.push_back(CHAR_TAB);
        add_str(" -1.5;+.25;7.;;ab;.;-0;1.1234567");
        send_frame();
    endtask

    task automatic test_saturation();
        add_str("end99999;-21475;21474.83647;-21474.83648;4294967296999");
        frame_buf.push_back(CHAR_NUL);
        add_str("z");
        send_frame();
    endtask

    task automatic test_frame_ends();
        add_str("end  ;5;");
        send_frame();
        add_str("end;");
        send_frame();
        add_str("end");
        frame_buf.push_back(CHAR_NUL);
        send_frame();
        add_str("end 3");
        send_frame();
    endtask

    task automatic test_cell_limit();
        add_str("end");
        for (int i = 0; i < 17; i++) add_str("1;");
        add_str("9");
        send_frame();
    endtask

    task automatic test_random_frames(input int s_pct, input int r_pct, input int budget);
        int start;
        int n_fields;
        int nd;
        int r;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = chars_sent;
        while (chars_sent - start < budget) begin
            if ($urandom_range(0, 99) < 15) begin
                nd = $urandom_range(1, 12);
                for (int i = 0; i < nd; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 2) == 0) add_str("end");
                nd = $urandom_range(0, 6);
                for (int i = 0; i < nd; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 9) < 3) begin
                    nd = $urandom_range(1, 3);
                    for (int i = 0; i < nd; i++) begin
                        frame_buf.push_back(8'($urandom_range(0, 255)));
                    end
                end
                case ($urandom_range(0, 9))
                    0:       add_str("eend");
                    1:       add_str("enend");
                    2:       add_str("en;end");
                    default: add_str("end");
                endcase
                n_fields = ($urandom_range(0, 99) < 15) ? $urandom_range(14, 19)
                                                        : $urandom_range(0, 6);
                for (int f = 0; f < n_fields; f++) begin
                    if (f > 0) frame_buf.push_back(CHAR_SEMI);
                    r = $urandom_range(0, 99);
                    if (r < 8) continue;
                    if (r < 25) begin
                        nd = $urandom_range(1, 2);
                        for (int i = 0; i < nd; i++) begin
                            frame_buf.push_back(($urandom_range(0, 6) == 6) ? CHAR_SPACE
                                                : 8'($urandom_range(9, 13)));
                        end
                    end
                    case ($urandom_range(0, 3))
                        0:       frame_buf.push_back(CHAR_PLUS);
                        1:       frame_buf.push_back(CHAR_MINUS);
                        default: ;
                    endcase
                    nd = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 13)
                                                     : $urandom_range(0, 4);
                    for (int i = 0; i < nd; i++) begin
                        frame_buf.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        frame_buf.push_back(CHAR_DOT);
                        nd = $urandom_range(0, 7);
                        for (int i = 0; i < nd; i++) begin
                            frame_buf.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
                        end
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        frame_buf.push_back(8'($urandom_range(0, 255)));
                    end
                end
                case ($urandom_range(0, 3))
                    0: frame_buf.push_back(CHAR_SEMI);
                    1: begin
                        frame_buf.push_back(CHAR_NUL);
                        nd = $urandom_range(0, 2);
                        for (int i = 0; i < nd; i++) begin
                            frame_buf.push_back(8'($urandom_range(0, 255)));
                        end
                    end
                    default: ;
                endcase
            end
            send_frame();
        end
    endtask

    // output held off long enough for the queue to fill and stall the input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = 300;
        hold_seq++;
        add_str("end1;2;3;4;5;6;7;8;9;10");
        send_frame();
        add_str("end-1;-2;-3;-4;-5");
        send_frame();
        wait_idle();
    endtask

    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_cells
        cell_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cells.size() == 0) begin
                errors++;
                $display("%0t: cell expected none, actual index %0d value %0d last %0b",
                         $time, m_tdata[3:0], $signed(m_tdata[35:4]), m_tlast);
            end else begin
                want = pending_cells.pop_front();
                cells_checked++;
                if (m_tdata[3:0] != want.index) begin
                    errors++;
                    $display("%0t: cell_index expected %0d actual %0d",
                             $time, want.index, m_tdata[3:0]);
                end
                if (m_tdata[35:4] != want.value) begin
                    errors++;
                    $display("%0t: cell_value expected %0d actual %0d",
                             $time, $signed(want.value), $signed(m_tdata[35:4]));
                end
                if (m_tlast != want.final_cell) begin
                    errors++;
                    $display("%0t: final_cell expected %0b actual %0b",
                             $time, want.final_cell, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("marker_framed_decimal_field_parser: mismatch");
            $finish;
        end
    end

    initial begin
        reset_parser();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_no_marker();
        test_number_forms();
        test_saturation();
        test_frame_ends();
        test_cell_limit();
        wait_idle();

        test_random_frames(33, 47, 180);
        wait_idle();
        test_random_frames(47, 33, 180);
        wait_idle();
        test_backpressure();
        test_random_frames(0, 0, 180);
        wait_idle();

        $display("Sent %0d characters in %0d frames, checked %0d cells.",
                 chars_sent, frames_sent, cells_checked);
        $display("Directed number forms and limits, random frames, idling and a long hold-off.");
        if (errors == 0 && pending_cells.size() == 0) begin
            $display("marker_framed_decimal_field_parser: match");
        end else begin
            $display("marker_framed_decimal_field_parser: mismatch");
        end
        $finish;
    end

endmodule

// File: marker_framed_decimal_field_parser.f
src/mfdp_pkg.sv
src/mfdp_front.sv
src/mfdp_queue.sv
src/mfdp_back.sv
src/marker_framed_decimal_field_parser.sv
tb/tb.sv
